@@ rtl/scmrv_pkg.sv @@
// shared types, constants and helper functions of the scan minimum range unit
package scmrv_pkg;

  localparam int unsigned RangeW     = 16;
  localparam int unsigned AngleW     = 24;
  localparam int unsigned IntervalW  = 20;
  localparam int unsigned StepW      = 13;
  localparam int unsigned VelW       = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;
  // rate product: 17 bit signed difference times one million
  localparam int unsigned DiffW      = RangeW + 1;
  localparam int unsigned ProdW      = 37;
  localparam int unsigned MagW       = ProdW - 1;

  localparam logic signed [ProdW-1:0] UsPerSec = 37'sd1000000;
  localparam logic signed [AngleW-1:0] AngleMax = 24'sh7FFFFF;
  localparam logic signed [VelW-1:0]   VelMax   = 24'sh7FFFFF;
  localparam logic signed [VelW-1:0]   VelMin   = 24'sh800000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRangeFloor   = 3'd0,
    CfgRangeCeiling = 3'd1,
    CfgStartAngle   = 3'd2,
    CfgAngleStep    = 3'd3,
    CfgWindowLow    = 3'd4,
    CfgWindowHigh   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        [RangeW-1:0] range_floor;
    logic        [RangeW-1:0] range_ceiling;
    logic signed [15:0]       scan_start_angle;
    logic        [StepW-1:0]  angle_step;
    logic signed [15:0]       window_low;
    logic signed [15:0]       window_high;
  } cfg_t;

  // one finished scan handed from the front to the back
  typedef struct packed {
    logic        [RangeW-1:0]    near_range;
    logic signed [AngleW-1:0]    angle;
    logic        [IntervalW-1:0] interval;
  } scan_res_t;

  // sign and magnitude to a saturated 24 bit signed value
  function automatic logic signed [VelW-1:0] sat_mag(input logic neg,
                                                     input logic [MagW-1:0] mag);
    logic signed [VelW-1:0] res;
    if (!neg && (mag > MagW'(24'h7FFFFF))) begin
      res = VelMax;
    end else if (neg && (mag > MagW'(24'h800000))) begin
      res = VelMin;
    end else if (neg) begin
      res = -$signed(mag[VelW-1:0]);
    end else begin
      res = $signed(mag[VelW-1:0]);
    end
    return res;
  endfunction

endpackage

@@ rtl/scmrv_if.sv @@
// stream channel interfaces for range samples and scan results
interface scmrv_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_sample;
  logic        last_in_scan;
  logic [19:0] scan_interval;

  modport source (output valid, output range_sample, output last_in_scan,
                  output scan_interval, input ready);
  modport sink   (input valid, input range_sample, input last_in_scan,
                  input scan_interval, output ready);
endinterface

interface scmrv_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] min_distance;
  logic signed [23:0] nearest_angle;
  logic signed [23:0] relative_velocity;

  modport source (output valid, output min_distance, output nearest_angle,
                  output relative_velocity, input ready);
  modport sink   (input valid, input min_distance, input nearest_angle,
                  input relative_velocity, output ready);
endinterface

@@ rtl/scmrv_ram.sv @@
// generic single write port ram with registered read
module scmrv_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/scmrv_front.sv @@
// front part: per ray minimum search inside the angle window
module scmrv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scmrv_pkg::cfg_t       cfg_i,
  scmrv_in_if.sink              in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output scmrv_pkg::scan_res_t  push_data_o
);

  localparam int unsigned AW = scmrv_pkg::AngleW;

  logic                              open_q, open_d;
  logic        [scmrv_pkg::RangeW-1:0] best_q, best_d, cur_best;
  logic signed [AW-1:0]              bang_q, bang_d, cur_bang;
  logic signed [AW-1:0]              ray_q, ray_d, cur_ray;
  logic signed [AW-1:0]              start_ang, win_lo, win_hi;
  logic signed [AW:0]                ray_sum;
  logic                              accept, hit;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid & push_ready_i;

  assign start_ang = AW'(cfg_i.scan_start_angle);
  assign win_lo    = AW'(cfg_i.window_low);
  assign win_hi    = AW'(cfg_i.window_high);

  // first ray of a scan takes the start values live
  assign cur_best = open_q ? best_q : cfg_i.range_ceiling;
  assign cur_bang = open_q ? bang_q : start_ang;
  assign cur_ray  = open_q ? ray_q  : start_ang;

  assign hit = (in_i.range_sample < cur_best) && (in_i.range_sample > cfg_i.range_floor) &&
               (cur_ray > win_lo) && (cur_ray < win_hi);

  assign ray_sum = (AW+1)'(cur_ray) + $signed({1'b0, (AW)'(cfg_i.angle_step)});

  always_comb begin
    best_d = hit ? in_i.range_sample : cur_best;
    bang_d = hit ? cur_ray : cur_bang;
    ray_d  = (ray_sum > (AW+1)'(scmrv_pkg::AngleMax)) ? scmrv_pkg::AngleMax
                                                       : ray_sum[AW-1:0];
    open_d = ~in_i.last_in_scan;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (accept) begin
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_q <= best_d;
      bang_q <= bang_d;
      ray_q  <= ray_d;
    end
  end

  assign push_valid_o           = accept & in_i.last_in_scan;
  assign push_data_o.near_range = best_d;
  assign push_data_o.angle      = bang_d;
  assign push_data_o.interval   = in_i.scan_interval;

endmodule

@@ rtl/scmrv_queue.sv @@
// short fifo of finished scans between front and back
module scmrv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  scmrv_pkg::scan_res_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output scmrv_pkg::scan_res_t pop_data_o
);

  localparam int unsigned Depth = scmrv_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  scmrv_pkg::scan_res_t entry_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/scmrv_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
module scmrv_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q, div_q;
  logic [VW:0]     rem_shift, rem_sub;
  logic            ge;

  assign rem_shift = {rem_q, quo_q[DW-1]};
  assign ge        = (rem_shift >= {1'b0, div_q});
  assign rem_sub   = rem_shift - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? rem_sub[VW-1:0] : rem_shift[VW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/scmrv_back.sv @@
// back part: per scan rate, history ring and moving average
module scmrv_back #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  scmrv_pkg::scan_res_t pop_data_i,
  scmrv_out_if.source          out_o
);

  localparam int unsigned VelW  = scmrv_pkg::VelW;
  localparam int unsigned MagW  = scmrv_pkg::MagW;
  localparam int unsigned ProdW = scmrv_pkg::ProdW;
  localparam int unsigned DiffW = scmrv_pkg::DiffW;
  localparam int unsigned IvW   = scmrv_pkg::IntervalW;
  localparam int unsigned PtrW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW  = VelW + $clog2(HISTORY_DEPTH);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMul    = 7'b0000010,
    StRateGo = 7'b0000100,
    StRate   = 7'b0001000,
    StUpdate = 7'b0010000,
    StAvgGo  = 7'b0100000,
    StAvg    = 7'b1000000
  } back_state_e;

  back_state_e state_q, state_d;

  logic        [scmrv_pkg::RangeW-1:0] dist_q, prev_q;
  logic signed [scmrv_pkg::AngleW-1:0] ang_q;
  logic        [IvW-1:0]               iv_q;
  logic signed [DiffW-1:0]             diff_q;
  logic signed [ProdW-1:0]             prod_q, prod_abs;
  logic signed [VelW-1:0]              old_q, rate_q;
  logic signed [SumW-1:0]              sum_q, sum_abs;
  logic        [PtrW-1:0]              ptr_q;
  logic        [CntW-1:0]              cnt_q;
  logic                                neg_q;
  logic                                out_valid_q;
  logic        [scmrv_pkg::RangeW-1:0] out_dist_q;
  logic signed [scmrv_pkg::AngleW-1:0] out_ang_q;
  logic signed [VelW-1:0]              out_vel_q;

  logic                div_start, div_done;
  logic [MagW-1:0]     div_dividend, div_quo;
  logic [IvW-1:0]      div_divisor;
  logic [VelW-1:0]     ram_rdata;
  logic                ram_we;
  logic signed [VelW-1:0] div_sat;

  assign pop_ready_o = (state_q == StIdle) && !out_valid_q;
  assign prod_abs    = prod_q[ProdW-1] ? -prod_q : prod_q;
  assign sum_abs     = sum_q[SumW-1] ? -sum_q : sum_q;
  assign div_sat     = scmrv_pkg::sat_mag(neg_q, div_quo);
  assign ram_we      = (state_q == StUpdate);

  // one divider serves the rate and then the average
  always_comb begin
    div_start    = (state_q == StRateGo) || (state_q == StAvgGo);
    div_dividend = prod_abs[MagW-1:0];
    div_divisor  = iv_q;
    if (state_q == StAvgGo) begin
      div_dividend = MagW'($unsigned(sum_abs));
      div_divisor  = IvW'(cnt_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (pop_valid_i && !out_valid_q) state_d = StMul;
      StMul:    state_d = StRateGo;
      StRateGo: state_d = StRate;
      StRate:   if (div_done) state_d = StUpdate;
      StUpdate: state_d = StAvgGo;
      StAvgGo:  state_d = StAvg;
      StAvg:    if (div_done) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      sum_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StUpdate) begin
        sum_q  <= sum_q - SumW'(old_q) + SumW'(rate_q);
        ptr_q  <= (ptr_q == PtrW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
        prev_q <= dist_q;
        if (cnt_q < CntW'(HISTORY_DEPTH)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if ((state_q == StAvg) && div_done) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        dist_q <= pop_data_i.near_range;
        ang_q  <= pop_data_i.angle;
        iv_q   <= (pop_data_i.interval == '0) ? IvW'(1) : pop_data_i.interval;
        diff_q <= $signed({1'b0, pop_data_i.near_range}) - $signed({1'b0, prev_q});
      end
      StMul: begin
        prod_q <= ProdW'(diff_q) * scmrv_pkg::UsPerSec;
        // a slot not yet filled since reset counts as zero
        old_q  <= (cnt_q < CntW'(HISTORY_DEPTH)) ? '0 : $signed(ram_rdata);
      end
      StRateGo: neg_q <= prod_q[ProdW-1];
      StRate:   if (div_done) rate_q <= div_sat;
      StUpdate: ;
      StAvgGo:  neg_q <= sum_q[SumW-1];
      StAvg: begin
        if (div_done) begin
          out_dist_q <= dist_q;
          out_ang_q  <= ang_q;
          out_vel_q  <= div_sat;
        end
      end
      default: ;
    endcase
  end

  scmrv_div #(
    .DW (MagW),
    .VW (IvW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  scmrv_ram #(
    .Width (VelW),
    .Depth (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (rate_q),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.min_distance      = out_dist_q;
  assign out_o.nearest_angle     = out_ang_q;
  assign out_o.relative_velocity = out_vel_q;

endmodule

@@ rtl/scan_min_range_rel_velocity_unit.sv @@
// top level of the scan minimum range and relative velocity unit
//
//   channel  dir  handshake       payload
//   in_i     in   valid / ready   range_sample, last_in_scan, scan_interval
//   out_o    out  valid / ready   min_distance, nearest_angle, relative_velocity
//   cfg      in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// one range sample is taken every cycle while the scan queue has room
// the back part holds each finished scan while the shared bit-serial divider works out
// the rate after a multiply step, then the history update, then the average
// a new scan enters the back part only once it is through with the last one
// up to two finished scans wait in the queue; the front stalls only when it is full
// the result register holds until taken; the back starts no new scan meanwhile
// reset clears control state; the history ram needs no clearing pass
module scan_min_range_rel_velocity_unit #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scmrv_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [scmrv_pkg::CfgDataW-1:0]       cfg_data_i,
  scmrv_in_if.sink                             in_i,
  scmrv_out_if.source                          out_o
);

  scmrv_pkg::cfg_t      cfg_q;
  scmrv_pkg::scan_res_t push_data, pop_data;
  logic                 push_valid, push_ready, pop_valid, pop_ready;

  // configuration registers, to be written by the user only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_floor      <= 16'd0;
      cfg_q.range_ceiling    <= 16'd65535;
      cfg_q.scan_start_angle <= -16'sd25736;
      cfg_q.angle_step       <= 13'd51;
      cfg_q.window_low       <= -16'sd25736;
      cfg_q.window_high      <= 16'sd25736;
    end else if (cfg_we_i) begin
      unique case (scmrv_pkg::cfg_idx_e'(cfg_idx_i))
        scmrv_pkg::CfgRangeFloor:   cfg_q.range_floor      <= cfg_data_i;
        scmrv_pkg::CfgRangeCeiling: cfg_q.range_ceiling    <= cfg_data_i;
        scmrv_pkg::CfgStartAngle:   cfg_q.scan_start_angle <= $signed(cfg_data_i);
        scmrv_pkg::CfgAngleStep:    cfg_q.angle_step       <=
                                      cfg_data_i[scmrv_pkg::StepW-1:0];
        scmrv_pkg::CfgWindowLow:    cfg_q.window_low       <= $signed(cfg_data_i);
        scmrv_pkg::CfgWindowHigh:   cfg_q.window_high      <= $signed(cfg_data_i);
        default: ; // unused indexes are ignored
      endcase
    end
  end

  // ray by ray minimum search
  scmrv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // finished scans waiting for the back part
  scmrv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // rate, history and average per scan
  scmrv_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

@@ dv/tb_scan_min_range_rel_velocity_unit.sv @@
// self-checking testbench of the scan minimum range and relative velocity unit
`timescale 1ns / 1ps

module tb_scan_min_range_rel_velocity_unit;

  localparam int HIST_DEPTH  = 32;
  localparam int SETTLE      = 120;     // settle time for the back part after the last result
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK_RAYS  = 116;     // random rays per register setting

  // one range sample as it goes onto the input channel
  typedef struct {
    logic [15:0] rng;
    logic        last;
    logic [19:0] ivl;
  } ray_t;

  // one nearest obstacle result as the block should give it
  typedef struct {
    logic        [15:0] near_range;
    logic signed [23:0] angle;
    logic signed [23:0] vel;
  } nearest_t;

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we;
  logic [scmrv_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [scmrv_pkg::CfgDataW-1:0] cfg_data;

  scmrv_in_if  in_if ();
  scmrv_out_if out_if ();

  scan_min_range_rel_velocity_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // rays waiting to be sent, and results still owed by the block
  ray_t     ray_q[$];
  nearest_t nearest_q[$];

  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;

  // register copies as the block should hold them
  logic        [15:0] cfg_floor;
  logic        [15:0] cfg_ceiling;
  logic signed [15:0] cfg_start;
  logic        [12:0] cfg_step;
  logic signed [15:0] cfg_win_lo;
  logic signed [15:0] cfg_win_hi;

  // scan and rate history state of the predictor
  logic        [15:0] best_dist;
  logic signed [23:0] best_ang;
  logic signed [23:0] ray_ang;
  logic        [15:0] prev_dist;
  longint             rate_hist[HIST_DEPTH];
  longint             rate_sum;
  int                 rate_cnt;
  int                 rate_ptr;
  bit                 scan_open;

  // clock, 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // advance the nearest obstacle search by one ray; a last ray closes the scan
  task automatic track_nearest(input logic [15:0] rng, input logic last,
                               input logic [19:0] ivl);
    longint   div;
    longint   rate;
    longint   mean;
    nearest_t res;
    // scan start values are latched on the first ray
    if (!scan_open) begin
      best_dist = cfg_ceiling;
      best_ang  = cfg_start;
      ray_ang   = cfg_start;
      scan_open = 1'b1;
    end
    // strictly above the floor, strictly below the best so far, strictly inside the window
    if (best_dist > rng && rng > cfg_floor && ray_ang > cfg_win_lo && ray_ang < cfg_win_hi) begin
      best_dist = rng;
      best_ang  = ray_ang;
    end
    // ray angle saturates at the 24 bit limits
    ray_ang = 24'(clamp24(longint'(ray_ang) + longint'(cfg_step)));
    if (last) begin
      // a zero interval counts as one microsecond
      div  = (ivl == '0) ? 64'sd1 : longint'(ivl);
      rate = clamp24(((longint'(best_dist) - longint'(prev_dist)) * 64'sd1000000) / div);
      rate_sum           = rate_sum - rate_hist[rate_ptr];
      rate_hist[rate_ptr] = rate;
      rate_sum           = rate_sum + rate;
      rate_ptr           = (rate_ptr + 1 >= HIST_DEPTH) ? 0 : rate_ptr + 1;
      if (rate_cnt < HIST_DEPTH) rate_cnt++;
      mean = clamp24(rate_sum / longint'(rate_cnt));
      res.near_range = best_dist;
      res.angle      = best_ang;
      res.vel        = mean[23:0];
      nearest_q.push_back(res);
      prev_dist = best_dist;
      scan_open = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // driver: holds an item until taken, then pulls the next one from the queue
  always @(posedge clk_i or negedge rst_ni) begin : drive
    ray_t nxt;
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.range_sample  <= '0;
      in_if.last_in_scan  <= 1'b0;
      in_if.scan_interval <= '0;
    end else begin
      // the item on the bus is taken at this edge
      if (in_if.valid && in_if.ready) begin
        track_nearest(in_if.range_sample, in_if.last_in_scan, in_if.scan_interval);
      end
      if (!in_if.valid || in_if.ready) begin
        if (ray_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = ray_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.range_sample  <= nxt.rng;
          in_if.last_in_scan  <= nxt.last;
          in_if.scan_interval <= nxt.ivl;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each taken result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    nearest_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (nearest_q.size() == 0) begin
          $display("%0t unexpected result: range %0d angle %0d velocity %0d", $time,
                   out_if.min_distance, out_if.nearest_angle, out_if.relative_velocity);
          mismatches++;
        end else begin
          want = nearest_q.pop_front();
          check_field("min_distance", want.near_range, out_if.min_distance);
          check_field("nearest_angle", want.angle, out_if.nearest_angle);
          check_field("relative_velocity", want.vel, out_if.relative_velocity);
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_ray(input logic [15:0] rng, input logic last, input logic [19:0] ivl);
    ray_t r;
    r.rng  = rng;
    r.last = last;
    r.ivl  = ivl;
    ray_q.push_back(r);
  endtask

  // one scan of random rays, ranges biased towards the floor, the ceiling and the extremes
  task automatic add_random_scan(input int rays);
    logic [15:0] rng;
    logic [19:0] ivl;
    for (int i = 0; i < rays; i++) begin
      case ($urandom_range(9))
        0:       rng = 16'd0;
        1:       rng = 16'hFFFF;
        2:       rng = cfg_floor + 16'($urandom_range(3));
        3:       rng = cfg_ceiling - 16'($urandom_range(3));
        4, 5:    rng = 16'($urandom_range(2000));
        default: rng = 16'($urandom_range(65535));
      endcase
      if (i == rays - 1) begin
        case ($urandom_range(9))
          0:       ivl = 20'd0;
          1:       ivl = 20'd1;
          2:       ivl = 20'hFFFFF;
          3:       ivl = 20'($urandom_range(100, 1));
          default: ivl = 20'($urandom_range(1048575, 1));
        endcase
      end else begin
        // ignored unless last
        ivl = 20'($urandom_range(1048575));
      end
      add_ray(rng, i == rays - 1, ivl);
    end
  endtask

  task automatic write_reg(input scmrv_pkg::cfg_idx_e idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      scmrv_pkg::CfgRangeFloor:   cfg_floor   = data;
      scmrv_pkg::CfgRangeCeiling: cfg_ceiling = data;
      scmrv_pkg::CfgStartAngle:   cfg_start   = data;
      scmrv_pkg::CfgAngleStep:    cfg_step    = data[12:0];
      scmrv_pkg::CfgWindowLow:    cfg_win_lo  = data;
      scmrv_pkg::CfgWindowHigh:   cfg_win_hi  = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] floor_v, input logic [15:0] ceil_v,
                               input logic [15:0] start_v, input logic [15:0] step_v,
                               input logic [15:0] lo_v, input logic [15:0] hi_v);
    write_reg(scmrv_pkg::CfgRangeFloor, floor_v);
    write_reg(scmrv_pkg::CfgRangeCeiling, ceil_v);
    write_reg(scmrv_pkg::CfgStartAngle, start_v);
    write_reg(scmrv_pkg::CfgAngleStep, step_v);
    write_reg(scmrv_pkg::CfgWindowLow, lo_v);
    write_reg(scmrv_pkg::CfgWindowHigh, hi_v);
  endtask

  // wait until every ray is taken and every result is back, then let the back part settle
  task automatic drain();
    while (ray_q.size() != 0 || in_if.valid || nearest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] st;
    int          sent;
    int          rays;

    // inputs known from time zero
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.range_sample  = '0;
    in_if.last_in_scan  = 1'b0;
    in_if.scan_interval = '0;
    out_if.ready        = 1'b0;
    mismatches          = 0;
    cycles              = 0;

    // register and history values after reset
    cfg_floor   = 16'd0;
    cfg_ceiling = 16'hFFFF;
    cfg_start   = -16'sd25736;
    cfg_step    = 13'd51;
    cfg_win_lo  = -16'sd25736;
    cfg_win_hi  = 16'sd25736;
    best_dist   = 16'hFFFF;
    best_ang    = -24'sd25736;
    ray_ang     = -24'sd25736;
    prev_dist   = '0;
    rate_sum    = 0;
    rate_cnt    = 0;
    rate_ptr    = 0;
    scan_open   = 1'b0;
    foreach (rate_hist[i]) rate_hist[i] = 0;

    // first phase: sender rarely idles, receiver mostly stalls
    send_idle_pct = 6;
    recv_idle_pct = 72;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed scans at reset settings
    // single ray at the start angle, outside the window: ceiling result, zero interval
    add_ray(16'd0, 1'b1, 20'd0);
    // top range never beats the ceiling, zero never beats the floor, smallest wins
    add_ray(16'hFFFF, 1'b0, 20'hFFFFF);
    add_ray(16'd1000, 1'b0, 20'd0);
    add_ray(16'd1, 1'b0, 20'd5);
    add_ray(16'd0, 1'b0, 20'd7);
    add_ray(16'd500, 1'b1, 20'hFFFFF);
    // ceiling again with unit interval: rate saturates high
    add_ray(16'h8000, 1'b1, 20'd1);
    // near minimum inside the window with unit interval: rate saturates low
    add_ray(16'd7, 1'b0, 20'd1);
    add_ray(16'd3, 1'b1, 20'd1);
    // equal ranges keep the earlier ray
    add_ray(16'd200, 1'b0, 20'd1);
    add_ray(16'd200, 1'b0, 20'd1);
    add_ray(16'd200, 1'b1, 20'd1000);
    // floor value itself is rejected once the floor is raised later; here one above it
    add_ray(16'd1, 1'b0, 20'd0);
    add_ray(16'h7FFF, 1'b1, 20'h80000);
    drain();

    for (int k = 0; k < 6; k++) begin
      // idling pattern: two settings each of sender-light, receiver-light, none
      if (k < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 72;
      end else if (k < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (k)
        // widest window and widest step from the lowest start
        0: apply_setting(16'd0, 16'hFFFF, 16'h8000, 16'd8191, 16'h8000, 16'h7FFF);
        // nothing can qualify: top floor, zero ceiling, inverted window
        1: apply_setting(16'hFFFF, 16'd0, 16'h7FFF, 16'd8191, 16'h7FFF, 16'h8000);
        // narrow window around zero, unit step
        2: apply_setting(16'd100, 16'd40000, 16'd0, 16'd1, 16'hFFF6, 16'd20);
        3: begin
          st = 16'($urandom_range(65535));
          apply_setting(16'($urandom_range(3000)), 16'($urandom_range(65535, 20000)), st,
                        16'($urandom_range(300)), st - 16'($urandom_range(2000)),
                        st + 16'($urandom_range(8000)));
        end
        // zero step: every ray at the start angle
        4: apply_setting(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1);
        default: apply_setting(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                               16'($urandom_range(65535)), 16'($urandom_range(8191)),
                               16'($urandom_range(65535)), 16'($urandom_range(65535)));
      endcase

      sent = 0;
      while (sent < CHUNK_RAYS) begin
        rays = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
        add_random_scan(rays);
        sent += rays;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
